### sv/lqrsf_pkg.sv
// shared types, constants and helpers of the lqr state feedback step unit
// no dependencies; the front, queue, back and top level import this package
`timescale 1ns / 1ps

package lqrsf_pkg;

	// defaults of the top level parameters
	localparam int NumJointsDef    = 4;
	localparam int NumActuatorsDef = 4;
	localparam int FracBitsDef     = 16;

	// depth of the queue between front and back
	localparam int QDepth = 2;
	localparam int QPtrW  = $clog2(QDepth);

	// saturation bounds for 32-bit results
	localparam logic signed [63:0] Max32 = 64'sd2147483647;
	localparam logic signed [63:0] Min32 = -64'sd2147483648;

	// input opcodes
	typedef enum logic [2:0] {
		OP_MEAS      = 3'd0,
		OP_GAIN      = 3'd1,
		OP_WEIGHT    = 3'd2,
		OP_EQ_TORQUE = 3'd3,
		OP_EQ_POS    = 3'd4
	} opcode_t;

	// item classes as decided by the front
	typedef enum logic [2:0] {
		K_GAIN,
		K_WEIGHT,
		K_EQ_TORQUE,
		K_EQ_POS,
		K_MEAS
	} kind_t;

	// one classified item in the queue
	typedef struct packed {
		kind_t              kind;
		logic [4:0]         row;
		logic [4:0]         col;
		logic signed [31:0] coef;
		logic signed [31:0] pos;
		logic signed [31:0] vel;
		logic signed [31:0] ref_pos;
		logic signed [31:0] ref_vel;
		logic               last;
		logic               store;
	} entry_t;

	// queue fill status
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// back end sequencer states
	typedef enum logic [4:0] {
		B_IDLE,
		B_M_POS,
		B_M_VEL,
		B_Q_RD,
		B_Q_MUL,
		B_Q_ACC,
		B_QR_RD,
		B_QR_MUL,
		B_QR_ACC,
		B_DIV_INIT,
		B_DIV,
		B_SQRT_INIT,
		B_SQRT,
		B_MARGIN,
		B_T_RD,
		B_T_MUL,
		B_T_ACC,
		B_T_EMIT
	} bstate_t;

	// saturate a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > Max32)
			r = Max32[31:0];
		else if (x < Min32)
			r = Min32[31:0];
		else
			r = x[31:0];
		return r;
	endfunction

endpackage

### sv/lqrsf_ifs.sv
// channel interfaces: input items, result items and the configuration write
// no dependencies
`timescale 1ns / 1ps

interface lqrsf_item_if;
	logic               valid;
	logic               ready;
	logic [2:0]         opcode;
	logic [4:0]         row_index;
	logic [4:0]         col_index;
	logic signed [31:0] coef_value;
	logic signed [31:0] joint_position;
	logic signed [31:0] joint_velocity;
	logic signed [31:0] ref_position;
	logic signed [31:0] ref_velocity;
	logic               last_joint;

	modport source (output valid, opcode, row_index, col_index, coef_value, joint_position,
		joint_velocity, ref_position, ref_velocity, last_joint, input ready);
	modport sink (input valid, opcode, row_index, col_index, coef_value, joint_position,
		joint_velocity, ref_position, ref_velocity, last_joint, output ready);
endinterface

interface lqrsf_result_if;
	logic               valid;
	logic               ready;
	logic [3:0]         actuator_index;
	logic signed [31:0] torque;
	logic signed [31:0] margin;
	logic               within_region;
	logic               last_result;

	modport source (output valid, actuator_index, torque, margin, within_region, last_result,
		input ready);
	modport sink (input valid, actuator_index, torque, margin, within_region, last_result,
		output ready);
endinterface

interface lqrsf_cfg_if;
	logic        valid;
	logic        ready;
	logic [30:0] trust_radius;

	modport source (output valid, trust_radius, input ready);
	modport sink (input valid, trust_radius, output ready);
endinterface

### sv/lqrsf_front.sv
// front end: accepts input items, drops meaningless ones, classifies the rest
// depends on lqrsf_pkg and lqrsf_item_if
`timescale 1ns / 1ps

module lqrsf_front import lqrsf_pkg::*; #(
	parameter int NUM_JOINTS    = NumJointsDef,
	parameter int NUM_ACTUATORS = NumActuatorsDef
) (
	lqrsf_item_if.sink item,
	input  q_status_t  qs,
	output logic       push,
	output entry_t     push_entry
);

	localparam int NS = 2 * NUM_JOINTS;

	logic keep;

	// take a transfer whenever the queue has room
	assign item.ready = !qs.full;

	// range checks and classification
	always_comb begin
		keep            = 1'b0;
		push_entry.kind = K_MEAS;
		unique case (item.opcode)
			OP_MEAS: begin
				push_entry.kind = K_MEAS;
				keep = ({1'b0, item.row_index} < 6'(NUM_JOINTS)) || item.last_joint;
			end
			OP_GAIN: begin
				push_entry.kind = K_GAIN;
				keep = ({1'b0, item.row_index} < 6'(NUM_ACTUATORS))
					&& ({1'b0, item.col_index} < 6'(NS));
			end
			OP_WEIGHT: begin
				push_entry.kind = K_WEIGHT;
				keep = ({1'b0, item.row_index} < 6'(NS)) && ({1'b0, item.col_index} < 6'(NS));
			end
			OP_EQ_TORQUE: begin
				push_entry.kind = K_EQ_TORQUE;
				keep = {1'b0, item.row_index} < 6'(NUM_ACTUATORS);
			end
			OP_EQ_POS: begin
				push_entry.kind = K_EQ_POS;
				keep = {1'b0, item.row_index} < 6'(NUM_JOINTS);
			end
			default: keep = 1'b0;
		endcase
	end

	// payload into the queue
	assign push_entry.row     = item.row_index;
	assign push_entry.col     = item.col_index;
	assign push_entry.coef    = item.coef_value;
	assign push_entry.pos     = item.joint_position;
	assign push_entry.vel     = item.joint_velocity;
	assign push_entry.ref_pos = item.ref_position;
	assign push_entry.ref_vel = item.ref_velocity;
	assign push_entry.last    = item.last_joint;
	assign push_entry.store   = {1'b0, item.row_index} < 6'(NUM_JOINTS);

	assign push = item.valid && item.ready && keep;

endmodule

### sv/lqrsf_queue.sv
// short queue of classified items between front and back
// depends on lqrsf_pkg
`timescale 1ns / 1ps

module lqrsf_queue import lqrsf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  entry_t    push_entry,
	input  logic      pop,
	output entry_t    head,
	output q_status_t status
);

	entry_t                 mem_q [QDepth];
	logic [QPtrW-1:0]       wr_ptr_q;
	logic [QPtrW-1:0]       rd_ptr_q;
	logic [$clog2(QDepth+1)-1:0] count_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = (count_q == ($clog2(QDepth+1))'(QDepth));
	assign status.empty = (count_q == '0);

endmodule

### sv/lqrsf_back.sv
// back end: table writes, state stores, quadratic form, divide, square root and torques
// depends on lqrsf_pkg and lqrsf_result_if
`timescale 1ns / 1ps

module lqrsf_back import lqrsf_pkg::*; #(
	parameter int NUM_JOINTS    = NumJointsDef,
	parameter int NUM_ACTUATORS = NumActuatorsDef,
	parameter int FRAC_BITS     = FracBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  entry_t      head,
	input  logic        head_valid,
	input  logic [30:0] radius,
	output logic        pop,
	lqrsf_result_if.source result
);

	localparam int NS        = 2 * NUM_JOINTS;
	localparam int NSW       = $clog2(NS);
	localparam int AW        = (NUM_ACTUATORS > 1) ? $clog2(NUM_ACTUATORS) : 1;
	localparam int JW        = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
	localparam int GD        = NUM_ACTUATORS * NS;
	localparam int GAW       = $clog2(GD);
	localparam int WD        = NS * NS;
	localparam int WAW       = $clog2(WD);
	localparam int TW        = 38;
	localparam int DivSteps  = 64 + 2 * FRAC_BITS;
	localparam int DCW       = $clog2(DivSteps + 1);

	bstate_t state_q, state_d;

	// tables and stores
	logic signed [31:0] gain_mem   [GD];
	logic signed [31:0] weight_mem [WD];
	logic signed [31:0] err_mem    [NS];
	logic signed [31:0] dev_mem    [NS];
	logic signed [31:0] eqt_q      [NUM_ACTUATORS];
	logic signed [31:0] eqp_q      [NUM_JOINTS];
	logic signed [31:0] diag_q     [NS];
	logic signed [TW-1:0] trace_sum_q;

	logic [NSW-1:0] i_q, j_q;
	logic [AW-1:0]  a_q;
	logic [DCW-1:0] div_cnt_q;

	logic signed [31:0] w_rd_q, g_rd_q, err_rd_q, dev_rd_q;
	logic signed [63:0] prod_q, acc_q, quad_q;
	logic [31:0]        den_q;
	logic [63:0]        num_q, quo_q, x_q, res_q, bit_q;
	logic [31:0]        rem_q;
	logic               div_sat_q;
	logic signed [31:0] margin_q;
	logic               out_valid_q;

	logic [JW-1:0]       jidx;
	logic [NSW-1:0]      nrow, ncol;
	logic [WAW-1:0]      w_rd_addr, w_wr_addr;
	logic [GAW-1:0]      g_rd_addr, g_wr_addr;
	logic [NSW-1:0]      dev_rd_addr;
	logic signed [31:0]  mul_a, mul_b, trace, acc_sat;
	logic signed [63:0]  rnd;
	logic                i_last, j_last, a_last, out_free;
	logic [32:0]         rem_try;
	logic                qbit;
	logic [31:0]         rem_next;
	logic [64:0]         sq_trial;
	logic signed [33:0]  margin_diff;

	assign jidx      = head.row[JW-1:0];
	assign nrow      = head.row[NSW-1:0];
	assign ncol      = head.col[NSW-1:0];
	assign i_last    = (i_q == NSW'(NS - 1));
	assign j_last    = (j_q == NSW'(NS - 1));
	assign a_last    = (a_q == AW'(NUM_ACTUATORS - 1));
	assign out_free  = !out_valid_q || result.ready;
	assign acc_sat   = sat32(acc_q);
	assign trace     = sat32(64'(trace_sum_q));

	// table addresses
	assign w_rd_addr   = WAW'(i_q) * WAW'(NS) + WAW'(j_q);
	assign w_wr_addr   = WAW'(nrow) * WAW'(NS) + WAW'(ncol);
	assign g_rd_addr   = GAW'(a_q) * GAW'(NS) + GAW'(i_q);
	assign g_wr_addr   = GAW'(head.row) * GAW'(NS) + GAW'(head.col);
	assign dev_rd_addr = (state_q == B_QR_RD) ? i_q : j_q;

	// next state and queue pop
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (head_valid) begin
					if (head.kind == K_MEAS)
						state_d = B_M_POS;
					else
						pop = 1'b1;
				end
			end
			B_M_POS:     state_d = B_M_VEL;
			B_M_VEL: begin
				pop     = 1'b1;
				state_d = head.last ? B_Q_RD : B_IDLE;
			end
			B_Q_RD:      state_d = B_Q_MUL;
			B_Q_MUL:     state_d = B_Q_ACC;
			B_Q_ACC:     state_d = j_last ? B_QR_RD : B_Q_RD;
			B_QR_RD:     state_d = B_QR_MUL;
			B_QR_MUL:    state_d = B_QR_ACC;
			B_QR_ACC:    state_d = i_last ? B_DIV_INIT : B_Q_RD;
			B_DIV_INIT:  state_d = quad_q[63] ? B_MARGIN : B_DIV;
			B_DIV:       state_d = (div_cnt_q == DCW'(DivSteps - 1)) ? B_SQRT_INIT : B_DIV;
			B_SQRT_INIT: state_d = B_SQRT;
			B_SQRT:      state_d = bit_q[0] ? B_MARGIN : B_SQRT;
			B_MARGIN:    state_d = B_T_RD;
			B_T_RD:      state_d = B_T_MUL;
			B_T_MUL:     state_d = B_T_ACC;
			B_T_ACC:     state_d = i_last ? B_T_EMIT : B_T_RD;
			B_T_EMIT: begin
				if (out_free)
					state_d = a_last ? B_IDLE : B_T_RD;
			end
			default:     state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= B_IDLE;
		else
			state_q <= state_d;
	end

	// shared multiplier operands and product rounding
	always_comb begin
		case (state_q)
			B_Q_MUL: begin
				mul_a = w_rd_q;
				mul_b = dev_rd_q;
			end
			B_QR_MUL: begin
				mul_a = dev_rd_q;
				mul_b = acc_sat;
			end
			default: begin
				mul_a = g_rd_q;
				mul_b = err_rd_q;
			end
		endcase
	end
	assign rnd = (prod_q + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

	// restoring divide step and square root trial
	assign rem_try  = {rem_q, num_q[63]};
	assign qbit     = (rem_try >= {1'b0, den_q});
	assign rem_next = qbit ? 32'(rem_try - {1'b0, den_q}) : rem_try[31:0];
	assign sq_trial = {1'b0, res_q} + {1'b0, bit_q};
	assign margin_diff = $signed({3'b000, radius}) - $signed({2'b00, res_q[31:0]});

	// table, store and memory reads
	always_ff @(posedge clk) begin
		w_rd_q   <= weight_mem[w_rd_addr];
		g_rd_q   <= gain_mem[g_rd_addr];
		err_rd_q <= err_mem[i_q];
		dev_rd_q <= dev_mem[dev_rd_addr];
	end

	// coefficient and measurement writes
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && head_valid) begin
			case (head.kind)
				K_GAIN:      gain_mem[g_wr_addr] <= head.coef;
				K_WEIGHT:    weight_mem[w_wr_addr] <= head.coef;
				K_EQ_TORQUE: eqt_q[head.row[AW-1:0]] <= head.coef;
				K_EQ_POS:    eqp_q[jidx] <= head.coef;
				default: ;
			endcase
		end
		if (state_q == B_M_POS && head.store) begin
			err_mem[NSW'(jidx)] <= sat32(64'(head.pos) - 64'(head.ref_pos));
			dev_mem[NSW'(jidx)] <= sat32(64'(head.pos) - 64'(eqp_q[jidx]));
		end
		if (state_q == B_M_VEL && head.store) begin
			err_mem[NSW'(jidx) + NSW'(NUM_JOINTS)] <= sat32(64'(head.vel) - 64'(head.ref_vel));
			dev_mem[NSW'(jidx) + NSW'(NUM_JOINTS)] <= head.vel;
		end
	end

	// running weight trace from diagonal writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trace_sum_q <= '0;
			for (int k = 0; k < NS; k++)
				diag_q[k] <= '0;
		end else if (state_q == B_IDLE && head_valid && head.kind == K_WEIGHT
				&& head.row == head.col) begin
			trace_sum_q  <= trace_sum_q - TW'(diag_q[nrow]) + TW'(head.coef);
			diag_q[nrow] <= head.coef;
		end
	end

	// loop counters and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q         <= '0;
			j_q         <= '0;
			a_q         <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (result.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				B_M_VEL: begin
					i_q <= '0;
					j_q <= '0;
				end
				B_Q_ACC:  j_q <= j_last ? '0 : j_q + 1'b1;
				B_QR_ACC: i_q <= i_last ? '0 : i_q + 1'b1;
				B_DIV_INIT: div_cnt_q <= '0;
				B_DIV:    div_cnt_q <= div_cnt_q + 1'b1;
				B_MARGIN: begin
					a_q <= '0;
					i_q <= '0;
				end
				B_T_ACC:  i_q <= i_last ? '0 : i_q + 1'b1;
				B_T_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						a_q         <= a_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// arithmetic datapath
	always_ff @(posedge clk) begin
		case (state_q)
			B_M_VEL: begin
				acc_q  <= '0;
				quad_q <= '0;
			end
			B_Q_MUL, B_QR_MUL, B_T_MUL: prod_q <= 64'(mul_a) * 64'(mul_b);
			B_Q_ACC:  acc_q <= acc_q + rnd;
			B_QR_ACC: begin
				quad_q <= quad_q + rnd;
				acc_q  <= '0;
			end
			B_DIV_INIT: begin
				num_q     <= quad_q;
				rem_q     <= '0;
				quo_q     <= '0;
				div_sat_q <= 1'b0;
				den_q     <= (trace > 32'sd0) ? 32'(trace) : (32'd1 << FRAC_BITS);
			end
			B_DIV: begin
				num_q     <= {num_q[62:0], 1'b0};
				rem_q     <= rem_next;
				quo_q     <= {quo_q[62:0], qbit};
				div_sat_q <= div_sat_q | quo_q[63];
			end
			B_SQRT_INIT: begin
				x_q   <= div_sat_q ? '1 : quo_q;
				res_q <= '0;
				bit_q <= 64'd1 << 62;
			end
			B_SQRT: begin
				if ({1'b0, x_q} >= sq_trial) begin
					x_q   <= x_q - sq_trial[63:0];
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			B_MARGIN: begin
				acc_q    <= '0;
				margin_q <= quad_q[63] ? Min32[31:0] : sat32(64'(margin_diff));
			end
			B_T_ACC:  acc_q <= acc_q + rnd;
			B_T_EMIT: begin
				if (out_free)
					acc_q <= '0;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == B_T_EMIT && out_free) begin
			result.actuator_index <= 4'(a_q);
			result.torque         <= sat32(64'(eqt_q[a_q]) - acc_q);
			result.margin         <= a_last ? margin_q : 32'sd0;
			result.within_region  <= a_last && !margin_q[31];
			result.last_result    <= a_last;
		end
	end

	assign result.valid = out_valid_q;

endmodule

### sv/lqr_state_feedback_step_unit.sv
// top level of the lqr state feedback step unit: front, queue, back and trust radius
// depends on lqrsf_pkg, lqrsf_ifs, lqrsf_front, lqrsf_queue and lqrsf_back
`timescale 1ns / 1ps

// LQR state feedback step. Coefficient items load the gain matrix, weight matrix,
// equilibrium torques and positions; a measurement item stores one joint's error
// and deviation; the item marked last joint triggers one torque result per actuator,
// the final one carrying the trust margin and the in-region flag. A coefficient
// write is done in the back end's idle state and a measurement in the idle,
// position and velocity states. A final sample is then worked through by the single
// shared 32x32 multiplier, which walks the weight and gain tables one product at a
// time in read, multiply and accumulate states, then by the bit-serial divider and
// square root. A two-entry queue lets the input side keep taking transfers while
// the back end works; the trust radius register is always ready.

module lqr_state_feedback_step_unit import lqrsf_pkg::*; #(
	parameter int NUM_JOINTS    = NumJointsDef,
	parameter int NUM_ACTUATORS = NumActuatorsDef,
	parameter int FRAC_BITS     = FracBitsDef
) (
	input  logic clk,
	input  logic arst_n,
	lqrsf_item_if.sink     item,
	lqrsf_result_if.source result,
	lqrsf_cfg_if.sink      cfg
);

	logic        push, pop;
	entry_t      push_entry, head;
	q_status_t   qs;
	logic [30:0] radius_q;

	// trust radius register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			radius_q <= '0;
		else if (cfg.valid)
			radius_q <= cfg.trust_radius;
	end

	lqrsf_front #(
		.NUM_JOINTS    (NUM_JOINTS),
		.NUM_ACTUATORS (NUM_ACTUATORS)
	) u_front (
		.item       (item),
		.qs         (qs),
		.push       (push),
		.push_entry (push_entry)
	);

	lqrsf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (qs)
	);

	lqrsf_back #(
		.NUM_JOINTS    (NUM_JOINTS),
		.NUM_ACTUATORS (NUM_ACTUATORS),
		.FRAC_BITS     (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!qs.empty),
		.radius     (radius_q),
		.pop        (pop),
		.result     (result)
	);

	// no push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qs.full) else $error("push into full queue");

	// no pop from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qs.empty) else $error("pop from empty queue");

	// in-region flag agrees with the margin sign on the final result
	a_region_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.last_result) |-> (result.within_region == !result.margin[31]))
		else $error("region flag disagrees with margin");

	// non-final results carry no margin
	a_nonfinal_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.last_result) |-> (result.margin == 32'sd0 && !result.within_region))
		else $error("margin on non-final result");

endmodule
